FILE: rtl/utf8_char_slice_core_defines.svh
// Assertion macros shared by the UTF-8 character slice RTL.
`ifndef UTF8_CHAR_SLICE_CORE_DEFINES_SVH
`define UTF8_CHAR_SLICE_CORE_DEFINES_SVH

// Both macros expect clk and rst_n in the scope where they are used.
`define U8CS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define U8CS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/u8cs_pkg.sv
// Types and constants shared by the UTF-8 character slice modules.
package u8cs_pkg;

    localparam int COUNT_WIDTH     = 32;
    localparam int TOTAL_WIDTH     = 32;
    localparam int LO_WIDTH        = 31;
    localparam int HI_WIDTH        = 32;
    localparam int SLICE_WIDTH     = 33;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int QDEPTH          = 2;
    localparam int QPTR_WIDTH      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_WIDTH      = $clog2(QDEPTH + 1);

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_START_POSITION = CFG_INDEX_WIDTH'(0);
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CHAR_COUNT     = CFG_INDEX_WIDTH'(1);

    typedef struct packed {
        logic [2:0][7:0]        pend;
        logic [1:0]             fill;
        logic [2:0]             glen;
        logic [COUNT_WIDTH-1:0] idx;
    } state_t;

    typedef struct packed {
        logic [3:0][7:0]        bytes;
        logic [3:0]             keep;
        logic                   is_end;
        logic [TOTAL_WIDTH-1:0] total;
    } bundle_t;

    typedef struct packed {
        logic    push;
        bundle_t bundle;
        state_t  nxt;
    } step_t;

endpackage

FILE: rtl/u8cs_decode.sv
// Character grouping and slice selection for one input word.
module u8cs_decode
    import u8cs_pkg::*;
(
    input  logic [7:0]          data_byte,
    input  logic                byte_present,
    input  logic                last_byte,
    input  state_t              cur,
    input  logic [LO_WIDTH-1:0] lo,
    input  logic [HI_WIDTH-1:0] hi,
    output step_t               step
);

    localparam logic [7:0] MASK2 = 8'hE0;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] MASK3 = 8'hF0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] MASK4 = 8'hF8;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if ((b & MASK2) == LEAD2) len = 3'd2;
        else if ((b & MASK3) == LEAD3) len = 3'd3;
        else if ((b & MASK4) == LEAD4) len = 3'd4;
        else len = 3'd1;
        return len;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] a,
                                                       input logic [2:0] k);
        logic [COUNT_WIDTH:0] s;
        s = {1'b0, a} + (COUNT_WIDTH+1)'(k);
        return s[COUNT_WIDTH] ? COUNT_MAX : s[COUNT_WIDTH-1:0];
    endfunction

    logic [3:0][7:0]        buf_b;
    logic [2:0]             m;
    logic [3:0]             ok;
    logic [COUNT_WIDTH-1:0] idx_j;
    logic [2:0]             len_b;
    logic [2:0]             pos;
    logic [2:0]             lb;
    logic [2:0]             nchar;
    logic [3:0][1:0]        char_of;

    // Bytes held from an open group come first, then the new byte.
    always_comb
    begin
        buf_b[0] = (cur.fill > 2'd0) ? cur.pend[0] : (byte_present ? data_byte : 8'h00);
        buf_b[1] = (cur.fill > 2'd1) ? cur.pend[1] :
                   ((cur.fill == 2'd1 && byte_present) ? data_byte : 8'h00);
        buf_b[2] = (cur.fill > 2'd2) ? cur.pend[2] :
                   ((cur.fill == 2'd2 && byte_present) ? data_byte : 8'h00);
        buf_b[3] = (cur.fill == 2'd3 && byte_present) ? data_byte : 8'h00;
        m        = 3'(cur.fill) + 3'(byte_present);
    end

    // Slice test for the next four character positions.
    always_comb
    begin
        idx_j = '0;
        for (int j = 0; j < 4; j++)
        begin
            idx_j = sat_add(cur.idx, 3'(j));
            ok[j] = (SLICE_WIDTH'(idx_j) >= SLICE_WIDTH'(lo)) &&
                    (SLICE_WIDTH'(idx_j) <  SLICE_WIDTH'(hi));
        end
    end

    // End of text: regroup the held bytes; a group that runs past the end
    // shrinks to a single byte.
    always_comb
    begin
        pos     = 3'd0;
        lb      = 3'd1;
        nchar   = 3'd0;
        char_of = '0;
        for (int j = 0; j < 4; j++)
        begin
            if (pos < m)
            begin
                lb = lead_len(buf_b[pos[1:0]]);
                if (pos + lb > m)
                    lb = 3'd1;
                for (int p = 0; p < 4; p++)
                begin
                    if (3'(p) >= pos && 3'(p) < pos + lb)
                        char_of[p] = 2'(j);
                end
                pos   = pos + lb;
                nchar = 3'(j + 1);
            end
        end
    end

    assign len_b = lead_len(data_byte);

    always_comb
    begin
        step               = '0;
        step.nxt           = cur;
        step.bundle.bytes  = buf_b;
        if (!last_byte)
        begin
            if (byte_present)
            begin
                if (cur.fill == 2'd0)
                begin
                    if (len_b == 3'd1)
                    begin
                        step.push        = ok[0];
                        step.bundle.keep = ok[0] ? 4'b0001 : 4'b0000;
                        step.nxt.idx     = sat_add(cur.idx, 3'd1);
                    end
                    else
                    begin
                        step.nxt.pend[0] = data_byte;
                        step.nxt.fill    = 2'd1;
                        step.nxt.glen    = len_b;
                    end
                end
                else if (3'(cur.fill) + 3'd1 >= cur.glen)
                begin
                    for (int p = 0; p < 4; p++)
                        step.bundle.keep[p] = ok[0] && (2'(p) <= cur.fill);
                    step.push     = ok[0];
                    step.nxt.idx  = sat_add(cur.idx, 3'd1);
                    step.nxt.fill = 2'd0;
                    step.nxt.glen = 3'd1;
                end
                else
                begin
                    for (int p = 0; p < 3; p++)
                    begin
                        if (2'(p) == cur.fill)
                            step.nxt.pend[p] = data_byte;
                    end
                    step.nxt.fill = cur.fill + 2'd1;
                end
            end
        end
        else
        begin
            for (int p = 0; p < 4; p++)
                step.bundle.keep[p] = (3'(p) < m) && ok[char_of[p]];
            step.push          = 1'b1;
            step.bundle.is_end = 1'b1;
            step.bundle.total  = TOTAL_WIDTH'(sat_add(cur.idx, nchar));
            step.nxt.pend      = '0;
            step.nxt.fill      = 2'd0;
            step.nxt.glen      = 3'd1;
            step.nxt.idx       = '0;
        end
    end

endmodule

FILE: rtl/u8cs_outq.sv
// Result queue and serializer: one character, or a text's last bytes, per entry; one byte out per word.
module u8cs_outq
    import u8cs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  bundle_t                push_bundle,
    output logic                   full,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [7:0]             out_byte,
    output logic                   out_valid,
    output logic                   slice_end,
    output logic [TOTAL_WIDTH-1:0] total_chars
);

    `include "utf8_char_slice_core_defines.svh"

    bundle_t                q_reg [QDEPTH];
    logic [QPTR_WIDTH-1:0]  head_reg, head_next;
    logic [QPTR_WIDTH-1:0]  tail_reg, tail_next;
    logic [QCNT_WIDTH-1:0]  count_reg, count_next;
    logic [3:0]             done_reg, done_next;

    logic                   res_valid_reg, res_valid_next;
    logic [7:0]             byte_reg, byte_next;
    logic                   bvalid_reg, bvalid_next;
    logic                   end_reg, end_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;

    bundle_t    head;
    logic       have;
    logic [3:0] rem;
    logic [1:0] sel;
    logic       last_piece;
    logic       load;
    logic       emit;
    logic       pop;

    function automatic logic [QPTR_WIDTH-1:0] ptr_inc(input logic [QPTR_WIDTH-1:0] p);
        return (p == QPTR_WIDTH'(QDEPTH - 1)) ? '0 : p + QPTR_WIDTH'(1);
    endfunction

    assign head       = q_reg[head_reg];
    assign have       = (count_reg != '0);
    assign rem        = head.keep & ~done_reg;
    assign last_piece = ((rem & (rem - 4'd1)) == 4'd0);
    assign load       = !res_valid_reg || !res_stall;
    assign emit       = have && load;
    assign pop        = emit && last_piece;
    assign full       = (count_reg == QCNT_WIDTH'(QDEPTH));

    always_comb
    begin
        sel = 2'd0;
        for (int k = 3; k >= 0; k--)
        begin
            if (rem[k])
                sel = 2'(k);
        end
    end

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg + QCNT_WIDTH'(push) - QCNT_WIDTH'(pop);
        done_next      = done_reg;
        res_valid_next = res_valid_reg;
        byte_next      = byte_reg;
        bvalid_next    = bvalid_reg;
        end_next       = end_reg;
        total_next     = total_reg;
        if (push)
            tail_next = ptr_inc(tail_reg);
        if (load)
            res_valid_next = emit;
        if (emit)
        begin
            // An end entry with nothing kept still gives one marker word.
            byte_next   = (rem != 4'd0) ? head.bytes[sel] : 8'h00;
            bvalid_next = (rem != 4'd0);
            end_next    = head.is_end && last_piece;
            total_next  = (head.is_end && last_piece) ? head.total : '0;
            if (last_piece)
            begin
                head_next = ptr_inc(head_reg);
                done_next = 4'd0;
            end
            else
            begin
                done_next = done_reg | (4'd1 << sel);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[tail_reg] <= push_bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            done_reg      <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        bvalid_reg <= bvalid_next;
        end_reg    <= end_next;
        total_reg  <= total_next;
    end

    assign res_valid   = res_valid_reg;
    assign out_byte    = byte_reg;
    assign out_valid   = bvalid_reg;
    assign slice_end   = end_reg;
    assign total_chars = total_reg;

    `U8CS_ASSERT_IMP(a_no_push_when_full, push, !full, "push into a full result queue")
    `U8CS_ASSERT_IMP(a_marker_is_end, res_valid_reg && !bvalid_reg, end_reg,
        "empty result word without the end mark")
    `U8CS_ASSERT_IMP(a_empty_entry_is_end, have && (head.keep == 4'd0), head.is_end,
        "queued entry with no kept bytes that does not end the text")

endmodule

FILE: rtl/utf8_char_slice_core.sv
// Top level of the UTF-8 character slice: input stage, grouping state and configuration.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   data_byte, byte_present, last_byte
//   res      from block res_valid / res_stall out_byte, out_valid, slice_end, total_chars
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// One input word is taken per cycle while in_stall is low; a word that closes a
// character of k kept bytes gives k result words, and the last word of a text gives
// up to four, all leaving through the output register at one word per cycle while
// res_stall is low, after passing the input stage and the result queue.
// The two-entry result queue sets how far the input runs ahead of the output.
// Reset clears the grouping state and the bounds, which act as start_position 1 and char_count 0.
// in_stall rises only when the queue is full and the waiting word has results.
module utf8_char_slice_core
    import u8cs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [7:0]                 data_byte,
    input  logic                       byte_present,
    input  logic                       last_byte,
    output logic                       res_valid,
    input  logic                       res_stall,
    output logic [7:0]                 out_byte,
    output logic                       out_valid,
    output logic                       slice_end,
    output logic [TOTAL_WIDTH-1:0]     total_chars,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [31:0]                cfg_data
);

    `include "utf8_char_slice_core_defines.svh"

    logic                a_valid_reg, a_valid_next;
    logic [7:0]          a_byte_reg;
    logic                a_present_reg;
    logic                a_last_reg;
    state_t              st_reg;
    logic [LO_WIDTH-1:0] lo_reg, lo_next;
    logic [LO_WIDTH-1:0] cnt_reg, cnt_next;
    logic [HI_WIDTH-1:0] hi_reg, hi_next;

    step_t       step;
    logic        full;
    logic        a_consume;
    logic        a_load;
    logic [31:0] start_m1;

    u8cs_decode u_decode
    (
        .data_byte    (a_byte_reg),
        .byte_present (a_present_reg),
        .last_byte    (a_last_reg),
        .cur          (st_reg),
        .lo           (lo_reg),
        .hi           (hi_reg),
        .step         (step)
    );

    u8cs_outq u_outq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (a_consume && step.push),
        .push_bundle (step.bundle),
        .full        (full),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .out_byte    (out_byte),
        .out_valid   (out_valid),
        .slice_end   (slice_end),
        .total_chars (total_chars)
    );

    assign a_consume    = a_valid_reg && (!step.push || !full);
    assign in_stall     = a_valid_reg && step.push && full;
    assign a_load       = !in_stall;
    assign a_valid_next = a_load ? in_valid : a_valid_reg;
    assign cfg_ready    = 1'b1;

    // The slice bounds are kept as a half-open range of 0-based positions,
    // recomputed at each write of start_position or char_count.
    assign start_m1 = cfg_data - 32'd1;

    always_comb
    begin
        lo_next  = lo_reg;
        cnt_next = cnt_reg;
        hi_next  = hi_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_START_POSITION:
                begin
                    lo_next = (cfg_data[31] || cfg_data == 32'd0) ? '0 : start_m1[LO_WIDTH-1:0];
                    hi_next = HI_WIDTH'(lo_next) + HI_WIDTH'(cnt_reg);
                end
                CFG_CHAR_COUNT:
                begin
                    cnt_next = cfg_data[31] ? '0 : cfg_data[LO_WIDTH-1:0];
                    hi_next  = HI_WIDTH'(lo_reg) + HI_WIDTH'(cnt_next);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            st_reg.pend <= '0;
            st_reg.fill <= 2'd0;
            st_reg.glen <= 3'd1;
            st_reg.idx  <= '0;
            lo_reg      <= '0;
            cnt_reg     <= '0;
            hi_reg      <= '0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (a_consume)
                st_reg <= step.nxt;
            lo_reg  <= lo_next;
            cnt_reg <= cnt_next;
            hi_reg  <= hi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_byte_reg    <= data_byte;
            a_present_reg <= byte_present;
            a_last_reg    <= last_byte;
        end
    end

    `U8CS_ASSERT_NXT(a_end_clears_state, a_consume && a_last_reg,
        (st_reg.fill == 2'd0) && (st_reg.idx == '0) && (st_reg.glen == 3'd1),
        "grouping state not cleared after the end of a text")
    `U8CS_ASSERT_IMP(a_open_group_fits, st_reg.fill != 2'd0,
        (st_reg.glen > 3'(st_reg.fill)) && (st_reg.glen >= 3'd2),
        "held bytes do not fit the open group")

endmodule
